/* hw/rtl/kpht_pkg.sv */
`default_nettype none

package kpht_pkg;

  localparam int KEY_IDX_W  = 4;
  localparam int TICK_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CODE_W     = 8;
  localparam int EVENT_W    = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd40;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 4'd1;

  localparam logic [EVENT_W-1:0] EV_PUSH   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_HOLD   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_FINISH = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_PUSHED = 4'b0010,
    PH_HELD   = 4'b0100,
    PH_DONE   = 4'b1000
  } key_phase_t;

  function automatic logic [CODE_W-1:0] keypad_glyph(input logic [KEY_IDX_W-1:0] idx);
    logic [CODE_W-1:0] c;
    unique case (idx)
      4'd0:    c = "1";
      4'd1:    c = "2";
      4'd2:    c = "3";
      4'd3:    c = "A";
      4'd4:    c = "4";
      4'd5:    c = "5";
      4'd6:    c = "6";
      4'd7:    c = "B";
      4'd8:    c = "7";
      4'd9:    c = "8";
      4'd10:   c = "9";
      4'd11:   c = "C";
      4'd12:   c = "*";
      4'd13:   c = "0";
      4'd14:   c = "#";
      default: c = "D";
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/keypad_press_hold_tracker.sv */
// Keypad press/hold tracker for a 4x4 matrix keypad.
//
// Input channel (in_valid/in_stall): one key sample per transfer, giving the
// key index, whether it reads as pressed, and the current millisecond tick.
// Output channel (out_valid/out_stall): zero or one event per sample, giving
// the key's ASCII character and the event kind (push, hold or finish).
// Configuration channel (cfg_valid/cfg_ready): writes the debounce time
// (index 0) and the hold time (index 1); other indexes are dropped. It is
// always ready and should only be used while no samples are in flight.
//
// An input transfer is held in the input register, and its event is
// registered in the result register. Throughput is one sample per cycle
// while the receiver does not stall: the per-key phase and change-tick store
// is read and updated between the registers and written back as the result
// register loads, so back-to-back samples of a key see each other's updates.
// Reset puts every key idle with a change tick of zero and loads the
// default register values. While the receiver stalls with a result waiting,
// the sample in the input register holds and in_stall is raised.
`default_nettype none

module keypad_press_hold_tracker
  import kpht_pkg::*;
#(
  parameter int NUM_KEYS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [KEY_IDX_W-1:0]   in_key_index,
  input  wire                   in_pressed,
  input  wire [TICK_W-1:0]      in_now_tick,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [CODE_W-1:0]     out_key_code,
  output logic [EVENT_W-1:0]    out_key_event,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_W-1:0]       cfg_data
);

  // Only sixteen indexes can be addressed, so larger key counts store no more.
  localparam int DEPTH = (NUM_KEYS < 16) ? NUM_KEYS : 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]     debounce_r;
  logic [CFG_W-1:0]     hold_r;

  key_phase_t           phase_r [DEPTH];
  logic [TICK_W-1:0]    tick_r  [DEPTH];

  logic                 s1_valid_r;
  logic [KEY_IDX_W-1:0] s1_key_r;
  logic                 s1_pressed_r;
  logic [TICK_W-1:0]    s1_now_r;

  logic                 out_valid_r;
  logic [CODE_W-1:0]    out_code_r;
  logic [EVENT_W-1:0]   out_event_r;

  logic                 advance;
  logic                 in_range;
  logic [IDX_W-1:0]     rd_idx;
  key_phase_t           phase_rd;
  logic [TICK_W-1:0]    tick_rd;
  logic [TICK_W-1:0]    elapsed;
  logic                 qualified;
  key_phase_t           phase_nxt;
  logic                 tick_upd;
  logic                 emit;
  logic [EVENT_W-1:0]   event_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      hold_r     <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DEBOUNCE) begin
        debounce_r <= cfg_data;
      end else if (cfg_index == REG_HOLD) begin
        hold_r <= cfg_data;
      end
    end
  end

  // A valid input sample holds while a result waits on a stalled receiver.
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_key_r     <= in_key_index;
      s1_pressed_r <= in_pressed;
      s1_now_r     <= in_now_tick;
    end
  end

  assign in_range  = 32'(s1_key_r) < NUM_KEYS;
  assign rd_idx    = IDX_W'(s1_key_r);
  assign phase_rd  = phase_r[rd_idx];
  assign tick_rd   = tick_r[rd_idx];
  assign elapsed   = s1_now_r - tick_rd;
  assign qualified = in_range && (elapsed >= {{(TICK_W-CFG_W){1'b0}}, debounce_r});

  always_comb begin
    phase_nxt = phase_rd;
    tick_upd  = 1'b0;
    emit      = 1'b0;
    event_nxt = EV_PUSH;
    unique case (phase_rd)
      PH_IDLE: begin
        if (s1_pressed_r) begin
          phase_nxt = PH_PUSHED;
          tick_upd  = 1'b1;
          emit      = 1'b1;
          event_nxt = EV_PUSH;
        end
      end
      PH_PUSHED: begin
        if (!s1_pressed_r) begin
          phase_nxt = PH_DONE;
          tick_upd  = 1'b1;
          emit      = 1'b1;
          event_nxt = EV_FINISH;
        end else if (elapsed >= {{(TICK_W-CFG_W){1'b0}}, hold_r}) begin
          phase_nxt = PH_HELD;
          emit      = 1'b1;
          event_nxt = EV_HOLD;
        end
      end
      PH_HELD: begin
        if (!s1_pressed_r) begin
          phase_nxt = PH_DONE;
          tick_upd  = 1'b1;
          emit      = 1'b1;
          event_nxt = EV_FINISH;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        phase_r[i] <= PH_IDLE;
        tick_r[i]  <= '0;
      end
    end else if (s1_valid_r && advance && qualified) begin
      phase_r[rd_idx] <= phase_nxt;
      if (tick_upd) begin
        tick_r[rd_idx] <= s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && qualified && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code_r  <= keypad_glyph(s1_key_r);
      out_event_r <= event_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_code  = out_code_r;
  assign out_key_event = out_event_r;

endmodule

`default_nettype wire

/* hw/rtl/kpht_checker.sv */
`default_nettype none

module kpht_checker
  import kpht_pkg::*;
(
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire [CODE_W-1:0]    out_key_code,
  input wire [EVENT_W-1:0]   out_key_event
);

  // A result held by the receiver keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_code) && $stable(out_key_event))
    else $error("stalled result changed");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_event == EV_PUSH || out_key_event == EV_HOLD ||
                   out_key_event == EV_FINISH))
    else $error("unknown event kind");

  // The input side only backs up when a result is stuck at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A fresh result traces back to an input transfer, through the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching sample");

endmodule

bind keypad_press_hold_tracker kpht_checker u_kpht_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_key_code  (out_key_code),
  .out_key_event (out_key_event)
);

`default_nettype wire

/* sim/keypad_press_hold_tracker_tb.sv */
`default_nettype none

module keypad_press_hold_tracker_tb;
  import kpht_pkg::*;

  localparam int TRACKED_KEYS = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SAMPLES_PER_SETTING = 85;
  localparam int NUM_SETTINGS = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST = 4'd15;
  // Characters of the keypad, key 0 in the top byte.
  localparam logic [16*CODE_W-1:0] KEY_GLYPHS = "123A456B789C*0#D";

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [EVENT_W-1:0] kind;
  } key_event_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_EVENT
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [KEY_IDX_W-1:0] key;
    logic                 pressed;
    logic [TICK_W-1:0]    tick;
    logic [CODE_W-1:0]    code;
    logic [EVENT_W-1:0]   ev;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KEY_IDX_W-1:0] in_key_index = '0;
  logic in_pressed = 1'b0;
  logic [TICK_W-1:0] in_now_tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CODE_W-1:0] out_key_code;
  logic [EVENT_W-1:0] out_key_event;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predictor state: per-key phase and tick of last change, plus the settings.
  key_phase_t key_stage [TRACKED_KEYS];
  logic [TICK_W-1:0] key_mark [TRACKED_KEYS];
  logic [CFG_W-1:0] debounce_set;
  logic [CFG_W-1:0] hold_set;

  key_event_t pending_events[$];
  probe_row_t probe_rows[$];
  logic key_level [TRACKED_KEYS];
  logic [TICK_W-1:0] wall_tick;
  bit quiet = 1'b0;
  int mismatches = 0;
  int unsigned cycles = 0;

  keypad_press_hold_tracker #(.NUM_KEYS(TRACKED_KEYS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_key_index(in_key_index),
    .in_pressed(in_pressed),
    .in_now_tick(in_now_tick),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_key_code(out_key_code),
    .out_key_event(out_key_event),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("keypad_press_hold_tracker_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 15);
  end

  // Handshake signals only move at rising edges, so the value seen at the
  // falling edge decides whether the next edge completes a transfer.
  always @(negedge clk) begin
    key_event_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: code %h kind %0d", out_key_code, out_key_event);
      end else begin
        want = pending_events.pop_front();
        if (out_key_code !== want.code || out_key_event !== want.kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: want code %h kind %0d, got code %h kind %0d",
                     want.code, want.kind, out_key_code, out_key_event);
        end
      end
    end
  end

  function automatic bit track_key(input logic [KEY_IDX_W-1:0] k, input logic p,
                                   input logic [TICK_W-1:0] t, output key_event_t ev);
    logic [TICK_W-1:0] since;
    bit fire;
    since = t - key_mark[k];
    fire = 1'b0;
    ev.code = KEY_GLYPHS[(15 - k) * CODE_W +: CODE_W];
    ev.kind = EV_PUSH;
    if (k >= TRACKED_KEYS || since < {16'd0, debounce_set})
      return 1'b0;
    case (key_stage[k])
      PH_IDLE: begin
        if (p) begin
          key_stage[k] = PH_PUSHED;
          key_mark[k] = t;
          fire = 1'b1;
        end
      end
      PH_PUSHED: begin
        if (!p) begin
          key_stage[k] = PH_DONE;
          key_mark[k] = t;
          ev.kind = EV_FINISH;
          fire = 1'b1;
        end else if (since >= {16'd0, hold_set}) begin
          key_stage[k] = PH_HELD;
          ev.kind = EV_HOLD;
          fire = 1'b1;
        end
      end
      PH_HELD: begin
        if (!p) begin
          key_stage[k] = PH_DONE;
          key_mark[k] = t;
          ev.kind = EV_FINISH;
          fire = 1'b1;
        end
      end
      default: key_stage[k] = PH_IDLE;
    endcase
    return fire;
  endfunction

  // Leaves in_valid high on return so that back-to-back samples need no
  // second assignment in the same step; gaps lower it.
  task automatic feed(input logic [KEY_IDX_W-1:0] k, input logic p,
                      input logic [TICK_W-1:0] t);
    bit ok;
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_index <= k;
    in_pressed <= p;
    in_now_tick <= t;
    do begin
      @(negedge clk);
      ok = (in_stall === 1'b0);
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic feed_tracked(input logic [KEY_IDX_W-1:0] k, input logic p,
                              input logic [TICK_W-1:0] t);
    key_event_t ev;
    feed(k, p, t);
    if (track_key(k, p, t, ev))
      pending_events.push_back(ev);
  endtask

  task automatic cfg_xfer(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    bit ok;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = (cfg_ready === 1'b1);
      @(posedge clk);
    end while (!ok);
    if (idx == REG_DEBOUNCE)
      debounce_set = val;
    else if (idx == REG_HOLD)
      hold_set = val;
  endtask

  // A sample may cause no event, so after the last expected event the block
  // is left to settle before anything else happens.
  task automatic settle();
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic row(input row_kind_t kind, input logic [KEY_IDX_W-1:0] k, input logic p,
                     input logic [TICK_W-1:0] t, input logic [CODE_W-1:0] code,
                     input logic [EVENT_W-1:0] ev);
    probe_row_t r;
    r.kind = kind;
    r.key = k;
    r.pressed = p;
    r.tick = t;
    r.code = code;
    r.ev = ev;
    probe_rows.push_back(r);
  endtask

  // Mostly keys going down and up in order on a rising tick scaled to the
  // current settings; now and then a sample with an arbitrary tick.
  task automatic run_random(input int count);
    int n;
    int span;
    logic [KEY_IDX_W-1:0] k;
    logic p;
    logic [TICK_W-1:0] t;
    span = (int'(debounce_set) + int'(hold_set)) / 4 + 4;
    wall_tick = $urandom;
    for (n = 0; n < count; n++) begin
      k = KEY_IDX_W'($urandom_range(0, TRACKED_KEYS - 1));
      if ($urandom_range(0, 99) < 10) begin
        p = 1'($urandom_range(0, 1));
        t = $urandom;
      end else begin
        if ($urandom_range(0, 99) < 30)
          key_level[k] = !key_level[k];
        wall_tick = wall_tick + $urandom_range(0, span);
        p = key_level[k];
        t = wall_tick;
      end
      feed_tracked(k, p, t);
    end
  endtask

  initial begin
    int i;
    int ph;
    logic [CFG_W-1:0] deb;
    logic [CFG_W-1:0] hld;
    key_event_t ev;
    probe_row_t r;

    for (i = 0; i < TRACKED_KEYS; i++) begin
      key_stage[i] = PH_IDLE;
      key_mark[i] = '0;
      key_level[i] = 1'b0;
    end
    debounce_set = DEBOUNCE_RESET;
    hold_set = HOLD_RESET;

    // Change ticks start at zero, so early samples fall inside the debounce.
    row(ROW_NONE, 4'd0, 1'b1, 32'd10, 8'd0, EV_PUSH);
    row(ROW_NONE, 4'd0, 1'b1, 32'd39, 8'd0, EV_PUSH);
    row(ROW_EVENT, 4'd0, 1'b1, 32'd40, "1", EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b1, 32'd79, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b1, 32'd539, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b1, 32'd540, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b1, 32'd2000, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b0, 32'd2000, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b0, 32'd2039, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b0, 32'd2040, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd0, 1'b0, 32'd3000, 8'd0, EV_PUSH);
    // Tick wraps between push and release of the last key.
    row(ROW_EVENT, 4'd15, 1'b1, 32'hFFFF_FFFF, "D", EV_PUSH);
    row(ROW_EVENT, 4'd15, 1'b0, 32'h0000_0027, "D", EV_FINISH);
    row(ROW_PREDICT, 4'd15, 1'b1, 32'h0000_004F, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd15, 1'b1, 32'h0000_0050, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd15, 1'b0, 32'h0000_0078, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd5, 1'b1, 32'h8000_0000, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd5, 1'b0, 32'h8000_0028, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd10, 1'b1, 32'h5555_AAAA, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd3, 1'b1, 32'hAAAA_5555, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd12, 1'b1, 32'd100, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd12, 1'b1, 32'd600, 8'd0, EV_PUSH);
    row(ROW_PREDICT, 4'd12, 1'b0, 32'd601, 8'd0, EV_PUSH);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (probe_rows.size() != 0) begin
      r = probe_rows.pop_front();
      if (r.kind == ROW_PREDICT) begin
        feed_tracked(r.key, r.pressed, r.tick);
      end else begin
        feed(r.key, r.pressed, r.tick);
        void'(track_key(r.key, r.pressed, r.tick, ev));
        if (r.kind == ROW_EVENT) begin
          ev.code = r.code;
          ev.kind = r.ev;
          pending_events.push_back(ev);
        end
      end
    end

    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph != 0) begin
        case (ph)
          1: begin deb = 16'd0;     hld = 16'd0;     end
          2: begin deb = 16'hFFFF;  hld = 16'hFFFF;  end
          3: begin deb = 16'd1;     hld = 16'd2;     end
          4: begin deb = 16'hFFFF;  hld = 16'd0;     end
          5: begin deb = 16'd0;     hld = 16'hFFFF;  end
          6: begin deb = 16'd12;    hld = 16'd90;    end
          default: begin deb = DEBOUNCE_RESET; hld = HOLD_RESET; end
        endcase
        in_valid <= 1'b0;
        settle();
        cfg_valid <= 1'b1;
        cfg_xfer(REG_DEBOUNCE, deb);
        cfg_xfer(REG_HOLD, hld);
        // Writes to unused indexes must leave both settings alone.
        cfg_xfer(REG_SPARE, CFG_W'($urandom));
        cfg_xfer(REG_LAST, CFG_W'($urandom));
        cfg_valid <= 1'b0;
      end
      quiet = (ph == 3);
      run_random(SAMPLES_PER_SETTING);
    end

    in_valid <= 1'b0;
    settle();
    if (mismatches == 0)
      $display("keypad_press_hold_tracker_tb: done, clean");
    else
      $display("keypad_press_hold_tracker_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

/* keypad_press_hold_tracker.f */
hw/rtl/kpht_pkg.sv
hw/rtl/keypad_press_hold_tracker.sv
hw/rtl/kpht_checker.sv
sim/keypad_press_hold_tracker_tb.sv
